@@ hdl/i2cms_pkg.sv @@
package i2cms_pkg;

	localparam int unsigned DATA_BITS = 8;
	localparam int unsigned ADDR_BITS = 7;

	localparam logic [3:0] OP_RELEASE = 4'd0;
	localparam logic [3:0] OP_START   = 4'd1;
	localparam logic [3:0] OP_RESTART = 4'd2;
	localparam logic [3:0] OP_STOP    = 4'd3;
	localparam logic [3:0] OP_ACK     = 4'd4;
	localparam logic [3:0] OP_NAK     = 4'd5;
	localparam logic [3:0] OP_SEND    = 4'd6;
	localparam logic [3:0] OP_READ    = 4'd7;
	localparam logic [3:0] OP_ADDR    = 4'd8;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_RELEASE = 4'd1;
	localparam logic [3:0] ST_START   = 4'd2;
	localparam logic [3:0] ST_RESTART = 4'd3;
	localparam logic [3:0] ST_STOP    = 4'd4;
	localparam logic [3:0] ST_ACK     = 4'd5;
	localparam logic [3:0] ST_NAK     = 4'd6;
	localparam logic [3:0] ST_SEND    = 4'd7;
	localparam logic [3:0] ST_READ    = 4'd8;

	localparam logic [1:0] LV_LO   = 2'd0;
	localparam logic [1:0] LV_HI   = 2'd1;
	localparam logic [1:0] LV_KEEP = 2'd2;

	typedef struct packed {
		logic [1:0] scl;
		logic [1:0] sda;
	} line_step_t;

	function automatic line_step_t mk(input logic [1:0] scl, input logic [1:0] sda);
		line_step_t r;
		r.scl = scl;
		r.sda = sda;
		return r;
	endfunction

	// Line drive for one phase of the short bus conditions.
	function automatic line_step_t short_step(input logic [3:0] st, input logic [1:0] ph);
		line_step_t r;
		r = mk(LV_KEEP, LV_KEEP);
		unique case (st)
			ST_RELEASE, ST_START, ST_RESTART: begin
				unique case (ph)
					2'd0: r = mk(LV_KEEP, (st == ST_START) ? LV_LO : LV_HI);
					2'd1: r = mk((st == ST_START) ? LV_LO : LV_HI, LV_KEEP);
					2'd2: r = mk(LV_KEEP, LV_LO);
					default: r = mk(LV_LO, LV_KEEP);
				endcase
			end
			ST_STOP: begin
				unique case (ph)
					2'd0: r = mk(LV_LO, LV_KEEP);
					2'd1: r = mk(LV_KEEP, LV_LO);
					2'd2: r = mk(LV_HI, LV_KEEP);
					default: r = mk(LV_KEEP, LV_HI);
				endcase
			end
			ST_ACK, ST_NAK: begin
				unique case (ph)
					2'd0: r = mk(LV_KEEP, (st == ST_ACK) ? LV_LO : LV_HI);
					2'd1: r = mk(LV_HI, LV_KEEP);
					2'd2: r = mk(LV_LO, LV_KEEP);
					default: r = mk(LV_KEEP, LV_HI);
				endcase
			end
			default: r = mk(LV_KEEP, LV_KEEP);
		endcase
		return r;
	endfunction

endpackage

@@ hdl/i2c_master_bit_sequencer.sv @@
// Channel   Handshake                 Payload
// input     in_valid / in_ready       cmd_valid, operation, write_byte, sda_in
// result    out_valid / out_ready     scl_out, sda_out, busy_res, done_res,
//                                     read_data, ack_received, cmd_rejected
// config    cfg_wr_en                 cfg_wr_data (slave address)
//
// One item is taken every cycle unless a result waits on out_ready; its result
// is registered first in the input register and then in the result register.
// The sequencer state is updated once per item as it passes from the input
// register to the result register.
// Reset is asynchronous: both lines released, idle, slave address zero.
// While out_valid is high and out_ready is low the result holds, the input
// register fills and then in_ready drops.
module i2c_master_bit_sequencer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                cmd_valid,
	input  logic [3:0]                          operation,
	input  logic [i2cms_pkg::DATA_BITS-1:0]     write_byte,
	input  logic                                sda_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                scl_out,
	output logic                                sda_out,
	output logic                                busy_res,
	output logic                                done_res,
	output logic [i2cms_pkg::DATA_BITS-1:0]     read_data,
	output logic                                ack_received,
	output logic                                cmd_rejected,
	input  logic                                cfg_wr_en,
	input  logic [i2cms_pkg::ADDR_BITS-1:0]     cfg_wr_data
);
	import i2cms_pkg::*;

	logic                 valid_s1;
	logic                 cmd_valid_s1;
	logic [3:0]           op_s1;
	logic [DATA_BITS-1:0] wbyte_s1;
	logic                 sda_in_s1;

	logic [ADDR_BITS-1:0] addr_q;
	logic [3:0]           state_q;
	logic [2:0]           phase_q;
	logic [3:0]           bit_q;
	logic [DATA_BITS-1:0] shift_q;
	logic                 scl_q;
	logic                 sda_q;
	logic                 ack_q;
	logic [DATA_BITS-1:0] rbyte_q;
	logic                 out_valid_q;

	logic                 out_free;
	logic                 adv;

	logic [3:0]           st_n;
	logic [2:0]           ph_n;
	logic [3:0]           bc_n;
	logic [DATA_BITS-1:0] sd_n;
	logic                 scl_n;
	logic                 sda_n;
	logic                 ack_n;
	logic [DATA_BITS-1:0] rb_n;
	logic                 rej_n;
	logic                 done_n;
	logic                 fin;
	line_step_t           step;

	assign out_free  = !out_valid_q || out_ready;
	assign adv       = valid_s1 && out_free;
	assign in_ready  = !valid_s1 || out_free;
	assign out_valid = out_valid_q;

	always_comb begin
		st_n   = state_q;
		ph_n   = phase_q;
		bc_n   = bit_q;
		sd_n   = shift_q;
		scl_n  = scl_q;
		sda_n  = sda_q;
		ack_n  = ack_q;
		rb_n   = rbyte_q;
		rej_n  = 1'b0;
		done_n = 1'b0;
		fin    = 1'b0;
		step   = short_step(ST_IDLE, 2'd0);

		if (cmd_valid_s1) begin
			if (state_q != ST_IDLE) begin
				rej_n = 1'b1;
			end else if (op_s1 <= OP_ADDR) begin
				ph_n = 3'd0;
				bc_n = 4'd0;
				priority if (op_s1 <= OP_NAK) begin
					st_n = op_s1 + 4'd1;
				end else if (op_s1 == OP_SEND) begin
					st_n = ST_SEND;
					sd_n = wbyte_s1;
				end else if (op_s1 == OP_READ) begin
					st_n = ST_READ;
					sd_n = '0;
				end else begin
					st_n = ST_SEND;
					sd_n = {addr_q, 1'b0};
				end
			end
		end

		if (st_n != ST_IDLE) begin
			unique case (st_n)
				ST_RELEASE, ST_START, ST_RESTART, ST_STOP, ST_ACK, ST_NAK: begin
					step = short_step(st_n, ph_n[1:0]);
					if (step.scl != LV_KEEP) scl_n = step.scl[0];
					if (step.sda != LV_KEEP) sda_n = step.sda[0];
					ph_n = ph_n + 3'd1;
					fin  = (st_n == ST_RELEASE || st_n == ST_START) ? (ph_n >= 3'd2)
					                                                : (ph_n >= 3'd4);
				end
				ST_SEND: begin
					if (bc_n <= 4'(DATA_BITS)) begin
						if (ph_n == 3'd0) begin
							scl_n = 1'b0;
							sda_n = (bc_n == 4'(DATA_BITS)) ? 1'b1 : sd_n[DATA_BITS-1];
							ph_n  = 3'd1;
						end else begin
							scl_n = 1'b1;
							if (bc_n == 4'(DATA_BITS)) begin
								ack_n = sda_in_s1;
							end else begin
								sd_n = {sd_n[DATA_BITS-2:0], 1'b0};
							end
							ph_n = 3'd0;
							bc_n = bc_n + 4'd1;
						end
					end else begin
						scl_n = 1'b0;
						fin   = 1'b1;
					end
				end
				ST_READ: begin
					if (bc_n < 4'(DATA_BITS)) begin
						if (ph_n == 3'd0) begin
							scl_n = 1'b0;
							sda_n = 1'b1;
							ph_n  = 3'd1;
						end else begin
							scl_n = 1'b1;
							sd_n  = {sd_n[DATA_BITS-2:0], sda_in_s1};
							ph_n  = 3'd0;
							bc_n  = bc_n + 4'd1;
						end
					end else begin
						scl_n = 1'b0;
						rb_n  = sd_n;
						fin   = 1'b1;
					end
				end
				default: fin = 1'b1;
			endcase
			if (fin) begin
				st_n   = ST_IDLE;
				ph_n   = 3'd0;
				bc_n   = 4'd0;
				done_n = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_valid_s1 <= cmd_valid;
			op_s1        <= operation;
			wbyte_s1     <= write_byte;
			sda_in_s1    <= sda_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
		end else if (cfg_wr_en) begin
			addr_q  <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ack_q   <= 1'b1;
			rbyte_q <= '0;
		end else if (adv) begin
			state_q <= st_n;
			phase_q <= ph_n;
			bit_q   <= bc_n;
			shift_q <= sd_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			ack_q   <= ack_n;
			rbyte_q <= rb_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			scl_out      <= scl_n;
			sda_out      <= sda_n;
			busy_res     <= (st_n != ST_IDLE);
			done_res     <= done_n;
			read_data    <= rb_n;
			ack_received <= ack_n;
			cmd_rejected <= rej_n;
		end
	end

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(done_res && busy_res))
		else $error("result reports done and busy together");

	a_reject_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		adv && cmd_valid_s1 && state_q != ST_IDLE |=> out_valid && cmd_rejected)
		else $error("command during a sequence was not rejected");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= 4'(DATA_BITS + 1))
		else $error("bit counter out of range");

	a_idle_counters: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> phase_q == 3'd0 && bit_q == 4'd0)
		else $error("counters not cleared while idle");

endmodule
